// ===== rtl/pcpf_pkg.sv =====
// pcpf_pkg: shared types and fixed-point constants of the plane contact force unit
// no dependencies

package pcpf_pkg;

    localparam int SLOT_W     = 3;
    localparam int GAIN_W     = 32;
    localparam int NORM_W     = 16;
    localparam int VEC_W      = 32;
    localparam int THR_W      = 31;
    localparam int REL_W      = VEC_W + 1;
    localparam int DOTP_W     = REL_W + NORM_W;
    localparam int S_W        = DOTP_W + 2;
    localparam int DOT_SH     = 14;
    localparam int GAIN_FRAC  = 16;
    localparam int DMAG_W     = 32;
    localparam int MPROD_W    = GAIN_W + DMAG_W;
    localparam int M_W        = MPROD_W - GAIN_FRAC;
    localparam int TERM_W     = MPROD_W - DOT_SH;
    localparam int FORCE_W    = 32;
    localparam int RND_HALF   = 1 << (DOT_SH - 1);
    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 3 * FORCE_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_VERTEX = 1'b1
    } t_op;

    // item moving along the cell chain
    typedef struct packed {
        t_op                          op;
        logic [SLOT_W-1:0]            slot;
        logic                         on;
        logic [GAIN_W-1:0]            gain;
        logic [2:0][NORM_W-1:0]       norm;
        logic [2:0][VEC_W-1:0]        vec;
    } t_item;

endpackage

// ===== rtl/plane_contact_penalty_force_unit.sv =====
// plane_contact_penalty_force_unit: penalty contact force of a vertex against a plane table
// the result passes the delay line of every plane cell in turn, then one output register
// throughput: one transfer per cycle; all cells advance together and hold while a result waits
// reset: clears pipeline valid bits and plane enables, threshold returns to 1.0
// plane gain, normal and center are undefined until loaded
// depends on pcpf_pkg and pcpf_cell

module plane_contact_penalty_force_unit #(
    parameter int PLANES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // plane_slot, plane_on, stiffness, norm_x, norm_y, norm_z, vec_x, vec_y, vec_z
    input  logic [pcpf_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // op
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // force_x, force_y, force_z
    output logic [pcpf_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pcpf_pkg::THR_W-1:0]          i_cfg_data
);

    localparam int ACC_W = pcpf_pkg::TERM_W + 1 + $clog2(PLANES);
    localparam logic signed [ACC_W-1:0] F_MAX =
        $signed({{(ACC_W - pcpf_pkg::FORCE_W + 1){1'b0}}, {(pcpf_pkg::FORCE_W - 1){1'b1}}});
    localparam logic signed [ACC_W-1:0] F_MIN =
        $signed({{(ACC_W - pcpf_pkg::FORCE_W + 1){1'b1}}, {(pcpf_pkg::FORCE_W - 1){1'b0}}});

    logic [pcpf_pkg::THR_W-1:0]         r_thr;
    logic                               r_out_vld;
    logic [pcpf_pkg::FORCE_W-1:0]       r_force [3];

    logic                               w_adv;
    logic                               w_vld [PLANES+1];
    pcpf_pkg::t_item                    w_item [PLANES+1];
    logic signed [ACC_W-1:0]            w_acc [PLANES+1][3];
    logic [pcpf_pkg::FORCE_W-1:0]       w_sat [3];
    logic                               w_last_vtx;

    always_comb begin
        w_item[0].op   = pcpf_pkg::t_op'(i_s_axis_tuser);
        w_item[0].slot = i_s_axis_tdata[2:0];
        w_item[0].on   = i_s_axis_tdata[3];
        w_item[0].gain = i_s_axis_tdata[35:4];
        w_item[0].norm[0] = i_s_axis_tdata[51:36];
        w_item[0].norm[1] = i_s_axis_tdata[67:52];
        w_item[0].norm[2] = i_s_axis_tdata[83:68];
        w_item[0].vec[0]  = i_s_axis_tdata[115:84];
        w_item[0].vec[1]  = i_s_axis_tdata[147:116];
        w_item[0].vec[2]  = i_s_axis_tdata[179:148];
        w_vld[0] = i_s_axis_tvalid;
        for (int a = 0; a < 3; a++) begin
            w_acc[0][a] = '0;
        end
    end

    genvar p;
    generate
        for (p = 0; p < PLANES; p++) begin : g_cell
            pcpf_cell #(
                .IDX   (p),
                .ACC_W (ACC_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_adv),
                .i_thr   (r_thr),
                .i_vld   (w_vld[p]),
                .i_item  (w_item[p]),
                .i_acc   (w_acc[p]),
                .o_vld   (w_vld[p+1]),
                .o_item  (w_item[p+1]),
                .o_acc   (w_acc[p+1])
            );
        end
    endgenerate

    // chain holds only when a vertex result is ready and the output is occupied and not taken
    always_comb begin
        w_last_vtx = w_vld[PLANES] && (w_item[PLANES].op == pcpf_pkg::OP_VERTEX);
        w_adv      = !w_last_vtx || !r_out_vld || i_m_axis_tready;
        for (int a = 0; a < 3; a++) begin
            if (w_acc[PLANES][a] > F_MAX) begin
                w_sat[a] = F_MAX[pcpf_pkg::FORCE_W-1:0];
            end else if (w_acc[PLANES][a] < F_MIN) begin
                w_sat[a] = F_MIN[pcpf_pkg::FORCE_W-1:0];
            end else begin
                w_sat[a] = w_acc[PLANES][a][pcpf_pkg::FORCE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= pcpf_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            r_out_vld <= w_last_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_axis_tready) begin
            for (int a = 0; a < 3; a++) begin
                r_force[a] <= w_sat[a];
            end
        end
    end

    assign o_s_axis_tready = w_adv;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_force[2], r_force[1], r_force[0]};

endmodule

// ===== rtl/pcpf_cell.sv =====
// pcpf_cell: one plane slot of the chain, holds its plane and adds its force term
// depends on pcpf_pkg

module pcpf_cell #(
    parameter int IDX   = 0,
    parameter int ACC_W = 54
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [pcpf_pkg::THR_W-1:0]      i_thr,
    input  logic                            i_vld,
    input  pcpf_pkg::t_item                 i_item,
    input  logic signed [ACC_W-1:0]         i_acc [3],
    output logic                            o_vld,
    output pcpf_pkg::t_item                 o_item,
    output logic signed [ACC_W-1:0]         o_acc [3]
);

    localparam int DEPTH = 10;
    localparam logic [pcpf_pkg::SLOT_W:0] IDX_V = (pcpf_pkg::SLOT_W + 1)'(IDX);
    localparam int THR_PAD = pcpf_pkg::S_W - pcpf_pkg::THR_W - pcpf_pkg::DOT_SH;
    localparam int SAT_LO  = pcpf_pkg::DOT_SH + pcpf_pkg::DMAG_W;

    // plane held by this cell
    logic                                   r_on;
    logic [pcpf_pkg::GAIN_W-1:0]            r_gain;
    logic signed [pcpf_pkg::NORM_W-1:0]     r_n [3];
    logic signed [pcpf_pkg::VEC_W-1:0]      r_c [3];

    // item delay line
    logic [DEPTH-1:0]                       r_vld;
    pcpf_pkg::t_item                        r_item [DEPTH];
    logic signed [ACC_W-1:0]                r_accd [DEPTH-1][3];

    // plane snapshot carried with the vertex
    logic signed [pcpf_pkg::NORM_W-1:0]     r_nd [7][3];
    logic [pcpf_pkg::GAIN_W-1:0]            r_gd [5];

    // datapath
    logic                                   r_act0, r_act1, r_act2;
    logic                                   r_hit3, r_hit4, r_hit5, r_hit6, r_hit7;
    logic signed [pcpf_pkg::REL_W-1:0]      r_rel [3];
    logic signed [pcpf_pkg::DOTP_W-1:0]     r_p [3];
    logic signed [pcpf_pkg::S_W-1:0]        r_s;
    logic [pcpf_pkg::S_W-1:0]               r_smag;
    logic [pcpf_pkg::DMAG_W-1:0]            r_dmag;
    logic [pcpf_pkg::MPROD_W-1:0]           r_prod;
    logic [pcpf_pkg::M_W-1:0]               r_m;
    logic [pcpf_pkg::MPROD_W-1:0]           r_t [3];
    logic [2:0]                             r_neg7, r_neg8;
    logic [pcpf_pkg::TERM_W-1:0]            r_term [3];
    logic signed [ACC_W-1:0]                r_acc9 [3];

    logic                                   w_load;
    logic signed [pcpf_pkg::S_W-1:0]        w_thr_s;
    logic [pcpf_pkg::S_W:0]                 w_rnd;
    logic [pcpf_pkg::NORM_W-1:0]            w_nmag [3];
    logic [pcpf_pkg::MPROD_W-1:0]           w_tr [3];
    logic signed [ACC_W-1:0]                w_term [3];

    always_comb begin
        w_load  = i_en && i_vld && (i_item.op == pcpf_pkg::OP_LOAD)
                  && ({1'b0, i_item.slot} == IDX_V);
        w_thr_s = $signed({{THR_PAD{1'b0}}, i_thr, {pcpf_pkg::DOT_SH{1'b0}}});
        w_rnd   = {1'b0, r_smag} + (pcpf_pkg::S_W + 1)'(pcpf_pkg::RND_HALF);
        for (int a = 0; a < 3; a++) begin
            w_nmag[a] = r_nd[6][a][pcpf_pkg::NORM_W-1] ? (~r_nd[6][a] + 1'b1) : r_nd[6][a];
            w_tr[a]   = r_t[a] + pcpf_pkg::MPROD_W'(pcpf_pkg::RND_HALF);
            w_term[a] = $signed({{(ACC_W - pcpf_pkg::TERM_W){1'b0}}, r_term[a]});
        end
    end

    // plane slot, written when a load transfer for this slot enters the cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on <= 1'b0;
        end else if (w_load) begin
            r_on <= i_item.on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_gain <= i_item.gain;
            for (int a = 0; a < 3; a++) begin
                r_n[a] <= i_item.norm[a];
                r_c[a] <= i_item.vec[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int k = 1; k < DEPTH; k++) begin
                r_item[k] <= r_item[k-1];
            end
            for (int a = 0; a < 3; a++) begin
                r_accd[0][a] <= i_acc[a];
                for (int k = 1; k < DEPTH - 1; k++) begin
                    r_accd[k][a] <= r_accd[k-1][a];
                end
                r_nd[0][a] <= r_n[a];
                for (int k = 1; k < 7; k++) begin
                    r_nd[k][a] <= r_nd[k-1][a];
                end
            end
            r_gd[0] <= r_gain;
            for (int k = 1; k < 5; k++) begin
                r_gd[k] <= r_gd[k-1];
            end

            // relative position, dot product, contact test
            r_act0 <= i_vld && (i_item.op == pcpf_pkg::OP_VERTEX) && r_on;
            r_act1 <= r_act0;
            r_act2 <= r_act1;
            for (int a = 0; a < 3; a++) begin
                r_rel[a] <= {i_item.vec[a][pcpf_pkg::VEC_W-1], i_item.vec[a]}
                            - {r_c[a][pcpf_pkg::VEC_W-1], r_c[a]};
                r_p[a]   <= r_rel[a] * r_nd[0][a];
            end
            r_s    <= r_p[0] + r_p[1] + r_p[2];
            r_hit3 <= r_act2 && (r_s < w_thr_s);
            r_smag <= r_s[pcpf_pkg::S_W-1] ? $unsigned(-r_s) : $unsigned(r_s);

            // distance magnitude, gain product
            r_hit4 <= r_hit3;
            r_dmag <= (|w_rnd[pcpf_pkg::S_W:SAT_LO]) ? '1
                      : w_rnd[SAT_LO-1:pcpf_pkg::DOT_SH];
            r_hit5 <= r_hit4;
            r_prod <= r_gd[4] * r_dmag;
            r_hit6 <= r_hit5;
            r_m    <= r_hit5 ? (r_prod[pcpf_pkg::MPROD_W-1:pcpf_pkg::GAIN_FRAC]
                               + pcpf_pkg::M_W'(r_prod[pcpf_pkg::GAIN_FRAC-1]))
                             : '0;

            // per-axis term and accumulate
            r_hit7 <= r_hit6;
            for (int a = 0; a < 3; a++) begin
                r_t[a]    <= r_m * w_nmag[a];
                r_neg7[a] <= r_nd[6][a][pcpf_pkg::NORM_W-1];
                r_neg8[a] <= r_neg7[a];
                r_term[a] <= r_hit7 ? w_tr[a][pcpf_pkg::MPROD_W-1:pcpf_pkg::DOT_SH] : '0;
                r_acc9[a] <= r_neg8[a] ? (r_accd[DEPTH-2][a] - w_term[a])
                                       : (r_accd[DEPTH-2][a] + w_term[a]);
            end
        end
    end

    always_comb begin
        o_vld  = r_vld[DEPTH-1];
        o_item = r_item[DEPTH-1];
        for (int a = 0; a < 3; a++) begin
            o_acc[a] = r_acc9[a];
        end
    end

endmodule
